/* src/sccs_pkg.sv */
package sccs_pkg;

  // counter and modulus widths
  localparam int CNT_W  = 16;
  localparam int MOD_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(MOD_W + 1);

  // full-range modulus, selected by register values 0 and 1
  localparam logic [MOD_W-1:0] MOD_FULL = {1'b1, {CNT_W{1'b0}}};

  // op codes
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // classification codes
  localparam logic [2:0] KIND_INITIAL      = 3'd0;
  localparam logic [2:0] KIND_RESTART      = 3'd1;
  localparam logic [2:0] KIND_DUPLICATE    = 3'd2;
  localparam logic [2:0] KIND_CONTINUOUS   = 3'd3;
  localparam logic [2:0] KIND_WRAP         = 3'd4;
  localparam logic [2:0] KIND_GAP          = 3'd5;
  localparam logic [2:0] KIND_OUT_OF_ORDER = 3'd6;

  // request into the shared remainder unit
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] dividend;
    logic [MOD_W-1:0] divisor;
  } rem_req_t;

  // status back from the remainder unit
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MOD_W-1:0] rem;
  } rem_rsp_t;

endpackage

/* src/sccs_rem_unit.sv */
module sccs_rem_unit
  import sccs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic [MOD_W-1:0]  quo_r, quo_nxt;
  logic [MOD_W-1:0]  rem_r, rem_nxt;
  logic [MOD_W-1:0]  div_r, div_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [MOD_W:0]    partial;
  logic [MOD_W:0]    diff;
  logic              ge;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign partial = {rem_r, quo_r[MOD_W-1]};
  assign diff    = partial - {1'b0, div_r};
  assign ge      = partial >= {1'b0, div_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      quo_nxt = {quo_r[MOD_W-2:0], 1'b0};
      rem_nxt = ge ? diff[MOD_W-1:0] : partial[MOD_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
      cnt_nxt  = STEP_W'(MOD_W);
      busy_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

/* src/sample_counter_sequence_checker_top.sv */
// Observe request: the result is loaded into the output register from the push step,
// and the next request is accepted only after that load, once the sequencer is idle.
// The result comes from two 17-step passes of the one shared remainder unit:
// modular distance to the expected value, then the successor of the value.
// A clear request gives no result.
// Synchronous active-low reset: history forgotten, modulus register 0 (full range).
module sample_counter_sequence_checker_top
  import sccs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_op,
  input  logic [CNT_W-1:0] in_actual,
  input  logic             in_restart_hint,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_kind,
  output logic [CNT_W-1:0] out_observed,
  output logic [CNT_W-1:0] out_previous,
  output logic             out_previous_valid,
  output logic [CNT_W-1:0] out_expected,
  output logic             out_expected_valid,
  output logic [CNT_W-1:0] out_missing_count,
  output logic             out_anomaly
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIFF = 2'd1;
  localparam logic [1:0] S_SUCC = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cfg_r;
  logic             hist_r, hist_nxt;
  logic [CNT_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0] act_r;
  logic             hint_r;
  logic [MOD_W-1:0] dist_r;
  logic             act_gt_r;
  logic [CNT_W-1:0] succ_r;

  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       kind_r;
  logic [CNT_W-1:0] observed_r, previous_r, expected_r, missing_r;
  logic             previous_valid_r, expected_valid_r, anomaly_r;

  logic             in_acc;
  logic             out_free;
  logic             push;
  logic [MOD_W-1:0] modulus;
  logic [CNT_W-1:0] abs_diff;
  rem_req_t         rem_req;
  rem_rsp_t         rem_rsp;

  logic [MOD_W-1:0] r_back;
  logic [MOD_W-1:0] f_dist, b_dist;
  logic [2:0]       kind_c;
  logic [CNT_W-1:0] miss_c;
  logic             anomaly_c;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign push     = (state_r == S_PUSH) && out_free;

  // effective modulus
  assign modulus = (cfg_r > CNT_W'(1)) ? {1'b0, cfg_r} : MOD_FULL;

  // distance between observed and expected, before reduction
  assign abs_diff = (in_actual > exp_r) ? (in_actual - exp_r) : (exp_r - in_actual);

  // shared remainder unit: distance first, then successor
  always_comb begin
    rem_req.divisor = modulus;
    if (state_r == S_IDLE) begin
      rem_req.start    = in_acc && (in_op == OP_OBSERVE);
      rem_req.dividend = {1'b0, abs_diff};
    end else begin
      rem_req.start    = (state_r == S_DIFF) && rem_rsp.done;
      rem_req.dividend = {1'b0, act_r} + MOD_W'(1);
    end
  end

  sccs_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // forward and backward modular distances from the reduced difference
  assign r_back = (dist_r == '0) ? '0 : (modulus - dist_r);
  assign f_dist = act_gt_r ? dist_r : r_back;
  assign b_dist = act_gt_r ? r_back : dist_r;

  // classification
  always_comb begin
    miss_c = '0;
    priority if (hist_r && hint_r) begin
      kind_c = KIND_RESTART;
    end else if (!hist_r) begin
      kind_c = KIND_INITIAL;
    end else if (act_r == last_r) begin
      kind_c = KIND_DUPLICATE;
    end else if (act_r == exp_r) begin
      kind_c = (act_r < last_r) ? KIND_WRAP : KIND_CONTINUOUS;
    end else if ((f_dist != '0) && (f_dist < b_dist)) begin
      kind_c = KIND_GAP;
      miss_c = f_dist[CNT_W-1:0];
    end else begin
      kind_c = KIND_OUT_OF_ORDER;
    end
  end

  assign anomaly_c = (kind_c == KIND_GAP) || (kind_c == KIND_DUPLICATE) ||
                     (kind_c == KIND_OUT_OF_ORDER);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_op == OP_OBSERVE)) state_nxt = S_DIFF;
      end
      S_DIFF: begin
        if (rem_rsp.done) state_nxt = S_SUCC;
      end
      S_SUCC: begin
        if (rem_rsp.done) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // history update: clear request or pushed observation that is not a duplicate
  always_comb begin
    hist_nxt = hist_r;
    last_nxt = last_r;
    exp_nxt  = exp_r;
    if (in_acc && (in_op == OP_CLEAR)) begin
      hist_nxt = 1'b0;
      last_nxt = '0;
      exp_nxt  = '0;
    end else if (push && (kind_c != KIND_DUPLICATE)) begin
      hist_nxt = 1'b1;
      last_nxt = act_r;
      exp_nxt  = succ_r;
    end
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= '0;
      hist_r      <= 1'b0;
      last_r      <= '0;
      exp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hist_r      <= hist_nxt;
      last_r      <= last_nxt;
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
    end
  end

  // captured request and intermediate results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_actual;
      hint_r   <= in_restart_hint;
      act_gt_r <= in_actual > exp_r;
    end
    if ((state_r == S_DIFF) && rem_rsp.done) dist_r <= rem_rsp.rem;
    if ((state_r == S_SUCC) && rem_rsp.done) succ_r <= rem_rsp.rem[CNT_W-1:0];
  end

  // result payload
  always_ff @(posedge clk) begin
    if (push) begin
      kind_r           <= kind_c;
      observed_r       <= act_r;
      previous_r       <= hist_r ? last_r : '0;
      previous_valid_r <= hist_r;
      expected_r       <= (hist_r && !hint_r) ? exp_r : '0;
      expected_valid_r <= hist_r && !hint_r;
      missing_r        <= miss_c;
      anomaly_r        <= anomaly_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_observed       = observed_r;
  assign out_previous       = previous_r;
  assign out_previous_valid = previous_valid_r;
  assign out_expected       = expected_r;
  assign out_expected_valid = expected_valid_r;
  assign out_missing_count  = missing_r;
  assign out_anomaly        = anomaly_r;

  // a result only appears from the push step
  a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUSH))
    else $error("result raised outside push step");

  // remainder unit only runs while requests are held off
  a_rem_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.busy |-> in_stall)
    else $error("remainder unit busy while idle");

  // a gap always reports a nonzero missing count
  a_gap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == KIND_GAP)) |-> (missing_r != '0))
    else $error("gap with zero missing count");

  // missing count only for gaps
  a_miss_only_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r != KIND_GAP)) |-> (missing_r == '0))
    else $error("missing count on non-gap result");

endmodule
